@@ hdl/rotation_to_euler_angles_unit_assert.svh @@
// Assertion macros for the rotation to Euler angles unit.
`ifndef ROTATION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define ROTATION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define R2E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Rotation to Euler angles unit: assertion failed.");
`define R2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("Rotation to Euler angles unit: assertion failed.");
`else
`define R2E_ASSERT_IMP(lbl, ante, cons)
`define R2E_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/r2e_pkg.sv @@
// Types, constants and helper functions for the rotation to Euler angles unit.
package r2e_pkg;

  typedef logic signed [31:0] mat_t;
  typedef logic signed [24:0] angle_t;
  typedef logic [30:0] thresh_t;

  localparam int CW = 35;
  typedef logic signed [CW-1:0] cord_t;

  localparam int LANES = 3;
  localparam int LANE_ROLL = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW = 2;

  localparam thresh_t THRESH_RESET = 31'd1074;
  localparam cord_t HALF_TURN = 35'sd3019898880;
  localparam cord_t ROUND_BIAS = 35'sd128;
  localparam cord_t SAT_HI = 35'sd11796480;
  localparam cord_t SAT_LO = -35'sd11796480;
  localparam angle_t ANG_SAT = 25'sd11796480;

  localparam int TAB_LEN = 32;
  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934, 30'd30029717, 30'd15018523, 30'd7509720,
    30'd3754917, 30'd1877466, 30'd938734, 30'd469367,
    30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833,
    30'd917, 30'd458, 30'd229, 30'd115,
    30'd57, 30'd29, 30'd14, 30'd7,
    30'd4, 30'd2, 30'd1, 30'd0
  };

  typedef struct packed {
    mat_t r00;
    mat_t r10;
    mat_t r20;
    mat_t r21;
    mat_t r22;
    mat_t r12;
    mat_t r11;
  } matrix_t;

  function automatic cord_t sext(mat_t v);
    return {{(CW-32){v[31]}}, v};
  endfunction

  function automatic angle_t finish_angle(cord_t z, logic zero);
    cord_t t;
    t = (z + ROUND_BIAS) >>> 8;
    if (zero) begin
      return '0;
    end else if (t > SAT_HI) begin
      return ANG_SAT;
    end else if (t < SAT_LO) begin
      return -ANG_SAT;
    end
    return t[24:0];
  endfunction

endpackage

@@ hdl/rotation_to_euler_angles_unit.sv @@
// Rotation matrix to Z-Y-X Euler angles, fully pipelined square root and CORDIC.
//
// A matrix transaction (r00, r10, r20, r21, r22, r12, r11 in signed Q1.30) is
// accepted when matrix_valid is high and matrix_stall is low. An angle
// transaction (roll_deg, pitch_deg, yaw_deg in signed Q8.16 degrees, plus the
// singular flag) is taken when angles_valid is high and angles_stall is low.
// One matrix can enter in every cycle that matrix_stall is low; results leave in
// order, one per matrix. The pipeline registers the absolute values, squares and
// sum, runs a bit-per-stage square root, registers the choice of vectors, runs
// CORDIC_STAGES (capped at TAB_LEN) shared-nothing CORDIC stages for the three
// angles, and ends in one output register.
// While angles_stall holds a waiting result, the whole pipeline freezes and
// matrix_stall is raised; nothing is dropped or repeated.
// The user must write the singular threshold through cfg_we and cfg_wdata while idle; the unit does not enforce it.
// Reset empties the pipeline and loads the threshold with 1074 (about 1e-6).
`include "rotation_to_euler_angles_unit_assert.svh"
module rotation_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  r2e_pkg::thresh_t cfg_wdata,
  input  logic             matrix_valid,
  output logic             matrix_stall,
  input  r2e_pkg::mat_t    r00,
  input  r2e_pkg::mat_t    r10,
  input  r2e_pkg::mat_t    r20,
  input  r2e_pkg::mat_t    r21,
  input  r2e_pkg::mat_t    r22,
  input  r2e_pkg::mat_t    r12,
  input  r2e_pkg::mat_t    r11,
  output logic             angles_valid,
  input  logic             angles_stall,
  output r2e_pkg::angle_t  roll_deg,
  output r2e_pkg::angle_t  pitch_deg,
  output r2e_pkg::angle_t  yaw_deg,
  output logic             singular
);
  import r2e_pkg::*;

  localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  thresh_t threshold;
  logic    adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  assign adv = !(angles_valid && angles_stall);
  assign matrix_stall = !adv;

  logic        v1, v2, v3;
  matrix_t     p1, p2;
  logic [31:0] m0, m1;
  logic [63:0] sq0, sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= matrix_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= '{r00: r00, r10: r10, r20: r20, r21: r21, r22: r22, r12: r12, r11: r11};
      m0 <= r00[31] ? 32'(-r00) : 32'(r00);
      m1 <= r10[31] ? 32'(-r10) : 32'(r10);
      p2 <= p1;
      sq0 <= m0 * m0;
      sq1 <= m1 * m1;
    end
  end

  logic [63:0] rrem [0:32];
  logic [31:0] rq   [0:32];
  matrix_t     rp   [0:32];
  logic [32:0] rv;

  assign rv[0] = v3;

  always_ff @(posedge clk) begin
    if (adv) begin
      rrem[0] <= sq0 + sq1;
      rq[0] <= '0;
      rp[0] <= p2;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_root
    localparam int K = 31 - j;
    logic [63:0] trial;
    assign trial = ({32'd0, rq[j]} << (K + 1)) | (64'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[j+1] <= 1'b0;
      end else if (adv) begin
        rv[j+1] <= rv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rp[j+1] <= rp[j];
        if (rrem[j] >= trial) begin
          rrem[j+1] <= rrem[j] - trial;
          rq[j+1] <= rq[j] | (32'd1 << K);
        end else begin
          rrem[j+1] <= rrem[j];
          rq[j+1] <= rq[j];
        end
      end
    end
  end

  cord_t       cx    [0:NS][0:LANES-1];
  cord_t       cy    [0:NS][0:LANES-1];
  cord_t       cz    [0:NS][0:LANES-1];
  logic        czero [0:NS][0:LANES-1];
  logic [NS:0] csing;
  logic [NS:0] cv;

  logic  sing_now;
  cord_t px [0:LANES-1];
  cord_t py [0:LANES-1];
  cord_t nx [0:LANES-1];
  cord_t ny [0:LANES-1];
  cord_t nz [0:LANES-1];
  logic  nzero [0:LANES-1];

  always_comb begin
    sing_now = rq[32] < {1'b0, threshold};
    px[LANE_ROLL] = sing_now ? sext(rp[32].r11) : sext(rp[32].r22);
    py[LANE_ROLL] = sing_now ? -sext(rp[32].r12) : sext(rp[32].r21);
    px[LANE_PITCH] = {{(CW-32){1'b0}}, rq[32]};
    py[LANE_PITCH] = -sext(rp[32].r20);
    px[LANE_YAW] = sext(rp[32].r00);
    py[LANE_YAW] = sext(rp[32].r10);
    for (int l = 0; l < LANES; l++) begin
      nzero[l] = (px[l] == '0) && (py[l] == '0);
      if (px[l][CW-1]) begin
        nx[l] = -px[l];
        ny[l] = -py[l];
        nz[l] = py[l][CW-1] ? -HALF_TURN : HALF_TURN;
      end else begin
        nx[l] = px[l];
        ny[l] = py[l];
        nz[l] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= rv[32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      csing[0] <= sing_now;
      for (int l = 0; l < LANES; l++) begin
        cx[0][l] <= nx[l];
        cy[0][l] <= ny[l];
        cz[0][l] <= nz[l];
        czero[0][l] <= nzero[l];
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam cord_t STEP = {{(CW-30){1'b0}}, ATAN_TAB[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        csing[i+1] <= csing[i];
        for (int l = 0; l < LANES; l++) begin
          czero[i+1][l] <= czero[i][l];
          if (!cy[i][l][CW-1] && (cy[i][l] != '0)) begin
            cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] + STEP;
          end else begin
            cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] - STEP;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angles_valid <= 1'b0;
    end else if (adv) begin
      angles_valid <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_deg <= finish_angle(cz[NS][LANE_ROLL], czero[NS][LANE_ROLL]);
      pitch_deg <= finish_angle(cz[NS][LANE_PITCH], czero[NS][LANE_PITCH]);
      yaw_deg <= finish_angle(cz[NS][LANE_YAW], czero[NS][LANE_YAW] || csing[NS]);
      singular <= csing[NS];
    end
  end

  `R2E_ASSERT_IMP(a_singular_yaw_zero, angles_valid && singular, yaw_deg == '0)
  `R2E_ASSERT_IMP(a_roll_in_range, angles_valid, roll_deg <= ANG_SAT && roll_deg >= -ANG_SAT)
  `R2E_ASSERT_IMP(a_stall_cause, matrix_stall, angles_valid && angles_stall)
  `R2E_ASSERT_NEXT(a_drain_moves, angles_valid && !angles_stall && !cv[NS], !angles_valid)

endmodule

@@ bench/rotation_to_euler_angles_unit_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts Euler angles for each matrix transaction and compares the results.
module rotation_to_euler_angles_unit_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  r2e_pkg::thresh_t cfg_wdata,
  input  logic             matrix_valid,
  input  logic             matrix_stall,
  input  r2e_pkg::mat_t    r00,
  input  r2e_pkg::mat_t    r10,
  input  r2e_pkg::mat_t    r20,
  input  r2e_pkg::mat_t    r21,
  input  r2e_pkg::mat_t    r22,
  input  r2e_pkg::mat_t    r12,
  input  r2e_pkg::mat_t    r11,
  input  logic             angles_valid,
  input  logic             angles_stall,
  input  r2e_pkg::angle_t  roll_deg,
  input  r2e_pkg::angle_t  pitch_deg,
  input  r2e_pkg::angle_t  yaw_deg,
  input  logic             singular,
  output int               errors,
  output int               pending
);
  import r2e_pkg::*;

  typedef struct {
    angle_t roll;
    angle_t pitch;
    angle_t yaw;
    logic   sing;
  } euler_t;

  euler_t  euler_q[$];
  thresh_t threshold;

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned res;
    longint unsigned bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > s) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (s >= res + bit_w) begin
        s = s - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic angle_t atan2_deg(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3019898880 : -64'sd3019898880;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TAB[i]);
      end
    end
    z = (z + 128) >>> 8;
    if (z > 11796480) z = 11796480;
    if (z < -11796480) z = -11796480;
    return z[24:0];
  endfunction

  function automatic euler_t predict_euler(longint a00, longint a10, longint a20, longint a21,
                                           longint a22, longint a12, longint a11,
                                           thresh_t thr);
    euler_t e;
    longint unsigned m0;
    longint unsigned m1;
    longint sy;
    m0 = (a00 < 0) ? -a00 : a00;
    m1 = (a10 < 0) ? -a10 : a10;
    sy = longint'(isqrt(m0 * m0 + m1 * m1));
    e.sing = (sy < longint'(thr));
    e.pitch = atan2_deg(-a20, sy);
    if (!e.sing) begin
      e.roll = atan2_deg(a21, a22);
      e.yaw = atan2_deg(a10, a00);
    end else begin
      e.roll = atan2_deg(-a12, a11);
      e.yaw = '0;
    end
    return e;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    euler_t want;
    if (rst) begin
      threshold <= THRESH_RESET;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (matrix_valid && !matrix_stall) begin
        euler_q.insert(euler_q.size(),
                       predict_euler(r00, r10, r20, r21, r22, r12, r11, threshold));
      end
      if (angles_valid && !angles_stall) begin
        if (euler_q.size() == 0) begin
          $display("%0t: angle transaction with none expected", $time);
          errors++;
        end else begin
          want = euler_q.pop_front();
          if (roll_deg !== want.roll) report_mismatch("roll_deg", roll_deg, want.roll);
          if (pitch_deg !== want.pitch) report_mismatch("pitch_deg", pitch_deg, want.pitch);
          if (yaw_deg !== want.yaw) report_mismatch("yaw_deg", yaw_deg, want.yaw);
          if (singular !== want.sing) report_mismatch("singular", singular, want.sing);
        end
      end
      pending <= euler_q.size();
    end
  end
endmodule

@@ bench/rotation_to_euler_angles_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives matrices, thresholds and stalls into the unit and gives the verdict.
module rotation_to_euler_angles_unit_tb;
  import r2e_pkg::*;

  localparam int STAGES = 24;
  localparam int DRAIN = STAGES + 50;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  thresh_t cfg_wdata = '0;
  logic    matrix_valid = 1'b0;
  logic    matrix_stall;
  mat_t    r00 = '0, r10 = '0, r20 = '0, r21 = '0, r22 = '0, r12 = '0, r11 = '0;
  logic    angles_valid;
  logic    angles_stall = 1'b0;
  angle_t  roll_deg, pitch_deg, yaw_deg;
  logic    singular;
  int      errors;
  int      pending;
  bit      quiet = 1'b0;
  int      stall_left = 0;

  always #10 clk = ~clk;

  rotation_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) i_dut (.*);

  rotation_to_euler_angles_unit_checker #(.CORDIC_STAGES(STAGES)) i_checker (.*);

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      angles_stall <= 1'b1;
    end else if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      angles_stall <= 1'b1;
    end else begin
      angles_stall <= 1'b0;
    end
  end

  task automatic send_matrix(mat_t a00, mat_t a10, mat_t a20, mat_t a21, mat_t a22,
                             mat_t a12, mat_t a11);
    bit taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      matrix_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    r00 <= a00; r10 <= a10; r20 <= a20; r21 <= a21;
    r22 <= a22; r12 <= a12; r11 <= a11;
    matrix_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !matrix_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic mat_t pick_entry(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 4000)) - 2000;
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  task automatic random_matrix();
    int k;
    int kx;
    k = $urandom_range(0, 9);
    kx = (k < 2) ? 0 : (k < 4) ? 1 : 2;
    send_matrix(pick_entry(kx), pick_entry(kx), pick_entry(k < 2 ? 0 : 2),
                pick_entry(k < 2 ? 0 : 2), pick_entry(k < 2 ? 0 : 2),
                pick_entry(k < 2 ? 0 : 2), pick_entry(k < 2 ? 0 : 2));
  endtask

  task automatic settle_and_write(thresh_t value);
    matrix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    mat_t specials [7];
    specials = '{32'sd0, 32'sh4000_0000, -32'sh4000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sd1, -32'sd1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (specials[i]) begin
      send_matrix(specials[i], specials[i], specials[i], specials[i], specials[i],
                  specials[i], specials[i]);
    end
    // Negative x with zero, positive and negative y, and the singular branch.
    send_matrix(-32'sh4000_0000, 0, 0, 0, -32'sh4000_0000, 0, -32'sh4000_0000);
    send_matrix(-32'sh4000_0000, 32'sd5, 32'sh4000_0000, 32'sd5, -32'sd7, 0, 0);
    send_matrix(-32'sh4000_0000, -32'sd5, -32'sh4000_0000, -32'sd5, -32'sd7, 0, 0);
    send_matrix(0, 0, 32'sh8000_0000, 0, 0, 32'sh8000_0000, 32'sd100);
    send_matrix(0, 0, -32'sh4000_0000, 0, 0, 0, 0);
    send_matrix(32'sd3, 32'sd4, 0, 32'sd1, 32'sd1, -32'sd9, -32'sd9);
    send_matrix(32'sd1073, 0, 0, 1, 1, 1, -32'sh4000_0000);
    send_matrix(32'sd1074, 0, 0, 1, 1, 1, -32'sh4000_0000);
    send_matrix(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 0, 0);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: settle_and_write('0);
        2: settle_and_write(31'h4000_0000);
        3: settle_and_write(thresh_t'($urandom_range(0, 32'h4000_0000)));
        4: settle_and_write(THRESH_RESET);
        default: ;
      endcase
      if (phase == 4) quiet = 1'b1;
      repeat (340) random_matrix();
    end
    matrix_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
